// ===== rtl/core/lfsa_pkg.sv =====
// Package for the lowest-free-slot interval allocator.
// Holds the item and result beat types and the opcode constants.
// No dependencies.
package lfsa_pkg;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic [4:0]  query_gates;
    } lfsa_item_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  gate_index;
        logic [31:0] served_total;
    } lfsa_result_t;

endpackage

// ===== rtl/core/lfsa_gate_bank.sv =====
// Gate bank: busy flags, end times and prefix served counts, with the
// free-gate search and the query read. Depends on lfsa_pkg.
module lfsa_gate_bank
    import lfsa_pkg::*;
#(
    parameter int GATES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  lfsa_item_t   item,
    input  logic [4:0]   gates_in_use,
    output lfsa_result_t result
);

    localparam int GW = (GATES > 1) ? $clog2(GATES) : 1;

    logic [GATES-1:0] busy_reg;
    logic [GATES-1:0] busy_next;
    logic [31:0]      until_reg  [GATES];
    logic [31:0]      until_next [GATES];
    logic [31:0]      prefix_reg [GATES];
    logic [31:0]      prefix_next[GATES];

    logic [GATES-1:0] freed;
    logic [GATES-1:0] avail;
    logic [GW-1:0]    sel;
    logic             hit;
    logic [GW-1:0]    qidx;

    always_comb
    begin
        for (int g = 0; g < GATES; g++)
        begin
            freed[g] = busy_reg[g] && (until_reg[g] <= item.start_time);
            avail[g] = (!busy_reg[g] || freed[g]) && (32'(gates_in_use) > g);
        end
        sel = '0;
        hit = 1'b0;
        for (int g = GATES - 1; g >= 0; g--)
        begin
            if (avail[g])
            begin
                sel = GW'(g);
                hit = 1'b1;
            end
        end
        if (32'(item.query_gates) >= GATES)
            qidx = GW'(GATES - 1);
        else
            qidx = GW'(item.query_gates - 5'd1);
    end

    always_comb
    begin
        busy_next = busy_reg;
        for (int g = 0; g < GATES; g++)
        begin
            until_next[g]  = until_reg[g];
            prefix_next[g] = prefix_reg[g];
        end
        result = '0;
        case (item.opcode)
            OP_REQUEST:
            begin
                busy_next = busy_reg & ~freed;
                if (hit)
                begin
                    busy_next[sel]  = 1'b1;
                    until_next[sel] = item.end_time;
                    for (int k = 0; k < GATES; k++)
                    begin
                        if (k >= 32'(sel) && prefix_reg[k] != COUNT_MAX)
                            prefix_next[k] = prefix_reg[k] + 32'd1;
                    end
                    result.granted    = 1'b1;
                    result.gate_index = 4'(sel);
                end
            end
            OP_QUERY:
            begin
                if (item.query_gates != 5'd0)
                    result.served_total = prefix_reg[qidx];
            end
            OP_CLEAR:
            begin
                busy_next = '0;
                for (int g = 0; g < GATES; g++)
                begin
                    until_next[g]  = '0;
                    prefix_next[g] = '0;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            for (int g = 0; g < GATES; g++)
            begin
                until_reg[g]  <= '0;
                prefix_reg[g] <= '0;
            end
        end
        else if (step)
        begin
            busy_reg <= busy_next;
            for (int g = 0; g < GATES; g++)
            begin
                until_reg[g]  <= until_next[g];
                prefix_reg[g] <= prefix_next[g];
            end
        end
    end

endmodule

// ===== rtl/core/lowest_free_slot_interval_allocator_top.sv =====
// Top level of the lowest-free-slot interval allocator.
// Input register, gate bank and result register. Depends on lfsa_pkg
// and lfsa_gate_bank.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one beat per interval
//   request, prefix count query or clear. result channel (result_valid/
//   result_ready/result) returns exactly one beat per item, in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) is always ready and writes
//   gates_in_use; the user writes it only while the block is idle (unchecked).
// Path: an accepted item sits in the input register while the gate
//   bank's end-time compares, lowest-free-gate search and prefix update
//   settle, and moves into the result register once that register is
//   empty or being read.
// Throughput: one item per cycle unless stalled; the gate state is updated
//   as an item enters the result register; the next item sees it at once.
// Reset: every gate free, all counts zero, gates_in_use = 16.
// Stall: while result_ready is low the result register holds, the input
//   register holds its item and item_ready drops once both are full.
module lowest_free_slot_interval_allocator_top
    import lfsa_pkg::*;
#(
    parameter int GATES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  lfsa_item_t   item,
    output logic         result_valid,
    input  logic         result_ready,
    output lfsa_result_t result,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data
);

    logic         stage_valid_reg;
    logic         stage_valid_next;
    lfsa_item_t   stage_item_reg;
    logic         result_valid_reg;
    logic         result_valid_next;
    lfsa_result_t result_reg;
    lfsa_result_t bank_result;
    logic [4:0]   gates_in_use_reg;
    logic         advance;
    logic         take;

    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;
    assign take       = item_valid && item_ready;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    lfsa_gate_bank #(
        .GATES(GATES)
    ) u_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (stage_item_reg),
        .gates_in_use(gates_in_use_reg),
        .result      (bank_result)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
        result_valid_next = result_valid_reg;
        if (advance)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            gates_in_use_reg <= 5'd16;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
                gates_in_use_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stage_item_reg <= item;
        if (advance)
            result_reg <= bank_result;
    end

    a_grant_no_total: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.granted |-> result_reg.served_total == 32'd0)
        else $error("granted beat carries a served total");

    a_refuse_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.granted |-> result_reg.gate_index == 4'd0)
        else $error("ungranted beat carries a gate index");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !advance |=> stage_valid_reg && $stable(stage_item_reg))
        else $error("input register dropped a stalled item");

    a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("advanced item did not reach the result register");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> item_ready)
        else $error("empty input register not ready");

endmodule

// ===== bench/lowest_free_slot_interval_allocator_top_tb.sv =====
// Testbench for the lowest-free-slot interval allocator top level.
// Predicts each result beat and checks it in order. Needs only lfsa_pkg
// and lowest_free_slot_interval_allocator_top.
module lowest_free_slot_interval_allocator_top_tb
    import lfsa_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NGATES = 16;
    localparam int CYCLE_LIMIT = 100000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_ready;
    lfsa_item_t   item;
    logic         result_valid;
    logic         result_ready;
    lfsa_result_t result;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [4:0]   cfg_data;

    logic         gate_held [NGATES];
    logic [31:0]  gate_free_at [NGATES];
    logic [31:0]  served_prefix [NGATES];
    logic [4:0]   gate_limit;

    lfsa_result_t pending_results [$];
    logic [31:0]  timeline;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_cycles;
    int           mismatches;
    int           cycle_count;

    lowest_free_slot_interval_allocator_top #(
        .GATES(NGATES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_gates();
        for (int g = 0; g < NGATES; g++)
        begin
            gate_held[g] = 1'b0;
            gate_free_at[g] = '0;
            served_prefix[g] = '0;
        end
    endfunction

    function automatic lfsa_result_t predict_allocation(input lfsa_item_t it);
        lfsa_result_t r;
        int           lim;
        bit           found;
        r = '0;
        found = 1'b0;
        case (it.opcode)
            OP_REQUEST:
            begin
                for (int g = 0; g < NGATES; g++)
                    if (gate_held[g] && gate_free_at[g] <= it.start_time)
                        gate_held[g] = 1'b0;
                lim = (gate_limit > NGATES) ? NGATES : int'(gate_limit);
                for (int g = 0; g < lim; g++)
                begin
                    if (!found && !gate_held[g])
                    begin
                        found = 1'b1;
                        gate_held[g] = 1'b1;
                        gate_free_at[g] = it.end_time;
                        for (int k = g; k < NGATES; k++)
                            if (served_prefix[k] != COUNT_MAX)
                                served_prefix[k]++;
                        r.granted = 1'b1;
                        r.gate_index = 4'(g);
                    end
                end
            end
            OP_QUERY:
            begin
                lim = (it.query_gates > NGATES) ? NGATES : int'(it.query_gates);
                if (lim > 0)
                    r.served_total = served_prefix[lim - 1];
            end
            OP_CLEAR:
                clear_gates();
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic lfsa_item_t make_item(input logic [1:0] op, input logic [31:0] s,
                                             input logic [31:0] e, input logic [4:0] q);
        lfsa_item_t it;
        it.opcode = op;
        it.start_time = s;
        it.end_time = e;
        it.query_gates = q;
        return it;
    endfunction

    function automatic lfsa_item_t random_item();
        lfsa_item_t it;
        int         pick;
        it.opcode = OP_REQUEST;
        it.start_time = $urandom;
        it.end_time = $urandom;
        it.query_gates = 5'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            if ($urandom_range(149) == 0)
                timeline = $urandom;
            timeline += $urandom_range(0, 4);
            it.start_time = timeline;
            it.end_time = timeline + $urandom_range(0, 48);
        end
        else if (pick < 85)
            it.opcode = OP_QUERY;
        else if (pick < 88)
            it.opcode = OP_CLEAR;
        else if (pick < 92)
            it.opcode = OP_UNUSED;
        return it;
    endfunction

    task automatic send_item(input lfsa_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        pending_results.push_back(predict_allocation(it));
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_gate_limit(input logic [4:0] value);
        wait_drained();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gate_limit = value;
    endtask

    task automatic test_directed();
        send_item(make_item(OP_QUERY, 32'd0, 32'd0, 5'd16));
        send_item(make_item(OP_REQUEST, 32'd0, 32'd0, 5'd0));
        send_item(make_item(OP_REQUEST, 32'd0, 32'd10, 5'd0));
        send_item(make_item(OP_REQUEST, 32'd0, 32'd10, 5'd0));
        send_item(make_item(OP_REQUEST, 32'd5, 32'd20, 5'd0));
        send_item(make_item(OP_REQUEST, 32'd10, 32'hFFFF_FFFF, 5'd0));
        send_item(make_item(OP_QUERY, 32'd0, 32'd0, 5'd0));
        send_item(make_item(OP_QUERY, 32'd0, 32'd0, 5'd1));
        send_item(make_item(OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31));
        send_item(make_item(OP_QUERY, 32'd0, 32'd0, 5'd17));
        send_item(make_item(OP_REQUEST, 32'd3, 32'd4, 5'd31));
        send_item(make_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31));
        send_item(make_item(OP_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0));
        send_item(make_item(OP_QUERY, 32'd0, 32'd0, 5'd16));
        send_item(make_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31));
        send_item(make_item(OP_QUERY, 32'd0, 32'd0, 5'd16));
        wait_drained();
    endtask

    task automatic test_gate_limits();
        logic [4:0] limits [5];
        int         fill;
        limits = '{5'd0, 5'd1, 5'd3, 5'd31, 5'd17};
        timeline = 32'd1000;
        foreach (limits[i])
        begin
            write_gate_limit(limits[i]);
            fill = (limits[i] > NGATES) ? NGATES : int'(limits[i]);
            send_item(make_item(OP_CLEAR, 32'd0, 32'd0, 5'd0));
            for (int n = 0; n <= fill; n++)
                send_item(make_item(OP_REQUEST, timeline, timeline + 32'd100, 5'd0));
            send_item(make_item(OP_QUERY, 32'd0, 32'd0, 5'd31));
            timeline += 32'd100;
            send_item(make_item(OP_REQUEST, timeline, timeline + 32'd1, 5'd0));
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct, input logic [4:0] limit);
        lfsa_item_t it;
        int         sent;
        write_gate_limit(limit);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < count)
        begin
            it = random_item();
            send_item(it);
            if (it.opcode != OP_UNUSED)
                sent++;
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_gate_limit(5'd16);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 150;
        repeat (40) send_item(random_item());
        wait_drained();
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_ready <= 1'b0;
                hold_cycles--;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        lfsa_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.granted !== want.granted)
                begin
                    $error("granted expected %0d got %0d", want.granted, result.granted);
                    mismatches++;
                end
                if (result.gate_index !== want.gate_index)
                begin
                    $error("gate_index expected %0d got %0d", want.gate_index,
                           result.gate_index);
                    mismatches++;
                end
                if (result.served_total !== want.served_total)
                begin
                    $error("served_total expected %0d got %0d", want.served_total,
                           result.served_total);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        timeline = '0;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        clear_gates();
        gate_limit = 5'd16;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_gate_limits();
        test_random_traffic(110, 0, 0, 5'd16);
        test_random_traffic(110, 83, 0, 5'($urandom_range(2, 15)));
        test_random_traffic(110, 0, 83, 5'd1);
        test_random_traffic(110, 11, 11, 5'd31);
        test_backpressure();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
